>>> design/sdiv_pkg.sv
// Shared types for the signed saturating divider.
// No dependencies; imported by the divider core and the top level.
`default_nettype none

package sdiv_pkg;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } t_sdiv_state;

    // Status from the magnitude divider core to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_sdiv_stat;

endpackage

`default_nettype wire

>>> design/signed_saturating_divider.sv
// Top level of the signed saturating divider: operand handling, sequencer, output register.
// Depends on sdiv_pkg and sdiv_core.
`default_nettype none

// Divides a signed two's complement dividend by a signed divisor, both
// DATA_WIDTH bits wide, and returns the quotient truncated toward zero.
// The magnitudes go through one shared subtract-and-compare unit that
// resolves one quotient bit per cycle: the accepting edge loads the
// core, DATA_WIDTH iterations follow, and the sign fix-up into the
// output register follows the core's registered done flag. The block
// accepts one request at a time; o_ready is high only while it is idle,
// which is again the case in the cycle after the result request has been
// taken. A new request is therefore accepted only after the result of
// the last one has been taken, and any stall on the result side holds
// off the next request. A zero divisor gives the largest positive value,
// as does the one overflow case, the most negative value divided by
// minus one. No flag is raised for either.
module signed_saturating_divider #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic signed [DATA_WIDTH-1:0] i_dividend,
    input  wire logic signed [DATA_WIDTH-1:0] i_divisor,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0]      o_quotient
);
    import sdiv_pkg::*;

    localparam logic [DATA_WIDTH-1:0] PosMax = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    t_sdiv_state           r_state, n_state;
    t_sdiv_stat            core_stat;
    logic [DATA_WIDTH-1:0] core_quo;
    logic                  accept;
    logic                  out_take;
    logic                  load_result;

    logic                  a_neg, b_neg;
    logic [DATA_WIDTH-1:0] a_mag, b_mag;

    // Per-request flags, captured at acceptance, and the output quotient register.
    logic                  r_neg_res, n_neg_res;
    logic                  r_zero_div, n_zero_div;
    logic [DATA_WIDTH-1:0] r_quotient, n_quotient;

    assign accept   = i_valid && o_ready;
    assign out_take = o_valid && i_ready;

    // Magnitudes as unsigned words: the most negative value maps to
    // 2^(DATA_WIDTH-1), which still fits.
    assign a_neg = i_dividend[DATA_WIDTH-1];
    assign b_neg = i_divisor[DATA_WIDTH-1];
    assign a_mag = a_neg ? (~i_dividend + 1'b1) : i_dividend;
    assign b_mag = b_neg ? (~i_divisor + 1'b1) : i_divisor;

    sdiv_core #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_num   (a_mag),
        .i_den   (b_mag),
        .o_stat  (core_stat),
        .o_quo   (core_quo)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (core_stat.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output decode of the sequencer.
    always_comb begin
        o_ready     = 1'b0;
        o_valid     = 1'b0;
        load_result = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
            end
            ST_DIV: begin
                load_result = core_stat.done;
            end
            ST_OUT: begin
                o_valid = 1'b1;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    // Sign fix-up and saturation. The magnitude quotient never exceeds
    // 2^(DATA_WIDTH-1), so its top bit alone flags the overflow case when
    // the result stays positive. A negated quotient always fits.
    always_comb begin
        n_neg_res  = r_neg_res;
        n_zero_div = r_zero_div;
        n_quotient = r_quotient;
        if (accept) begin
            n_neg_res  = (a_neg != b_neg) && (a_mag != '0);
            n_zero_div = (b_mag == '0);
        end
        if (load_result) begin
            if (r_zero_div) begin
                n_quotient = PosMax;
            end else if (r_neg_res) begin
                n_quotient = ~core_quo + 1'b1;
            end else if (core_quo[DATA_WIDTH-1]) begin
                n_quotient = PosMax;
            end else begin
                n_quotient = core_quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_neg_res  <= n_neg_res;
        r_zero_div <= n_zero_div;
        r_quotient <= n_quotient;
    end

    assign o_quotient = r_quotient;

endmodule

`default_nettype wire

>>> design/sdiv_core.sv
// Iterative restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Depends on sdiv_pkg for the status struct.
`default_nettype none

module sdiv_core #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [DATA_WIDTH-1:0]  i_num,
    input  wire logic [DATA_WIDTH-1:0]  i_den,
    output sdiv_pkg::t_sdiv_stat        o_stat,
    output logic      [DATA_WIDTH-1:0]  o_quo
);
    import sdiv_pkg::*;

    localparam int CntW = $clog2(DATA_WIDTH);
    localparam logic [CntW-1:0] LastStep = CntW'(DATA_WIDTH - 1);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CntW-1:0]       r_cnt, n_cnt;
    logic [DATA_WIDTH-1:0] r_rem, n_rem;
    logic [DATA_WIDTH-1:0] r_quo, n_quo;
    logic [DATA_WIDTH-1:0] r_den, n_den;
    logic [DATA_WIDTH-1:0] shifted;
    logic [DATA_WIDTH:0]   diff;

    // The quotient register starts out holding the numerator; its top bit
    // feeds the partial remainder while quotient bits enter from below.
    assign shifted = {r_rem[DATA_WIDTH-2:0], r_quo[DATA_WIDTH-1]};
    assign diff    = {1'b0, shifted} - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = diff[DATA_WIDTH] ? shifted : diff[DATA_WIDTH-1:0];
            n_quo = {r_quo[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LastStep) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;

endmodule

`default_nettype wire
